// ===== rtl/pdc_pkg.sv =====
`timescale 1ns / 1ps
package pdc_pkg;

  localparam int SAMPLE_BITS_DEF      = 16;
  localparam int CALIB_COUNT_BITS_DEF = 16;
  localparam int HOLD_BITS_DEF        = 24;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int REF_W      = 16;
  localparam int TOL_W      = 16;
  localparam int LEN_W      = 16;
  localparam int SLEEP_W    = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_CAL_EN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REF    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SLEEP  = 3'd4;

  localparam logic               RST_CAL_EN = 1'b1;
  localparam logic [REF_W-1:0]   RST_REF    = 16'd32768;
  localparam logic [TOL_W-1:0]   RST_TOL    = 16'd4096;
  localparam logic [LEN_W-1:0]   RST_LEN    = 16'd22050;
  localparam logic [SLEEP_W-1:0] RST_SLEEP  = 24'd441000;

  typedef enum logic [1:0] {
    DET_IDLE   = 2'd0,
    DET_ACTIVE = 2'd1,
    DET_UNSURE = 2'd2
  } det_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_DIV,
    ST_CMP,
    ST_WAIT
  } ctl_t;

  typedef struct packed {
    logic lo;
    logic lo_eq;
    logic hi;
    logic hi_eq;
  } band_t;

endpackage

// ===== rtl/pdc_accum.sv =====
`timescale 1ns / 1ps
module pdc_accum #(
  parameter int SAMPLE_BITS = pdc_pkg::SAMPLE_BITS_DEF,
  parameter int SUM_BITS    = pdc_pkg::SAMPLE_BITS_DEF + pdc_pkg::CALIB_COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   clear,
  input  logic                   start,
  input  logic [SAMPLE_BITS-1:0] sample,
  output logic [SUM_BITS-1:0]    sum,
  output logic                   done
);

  localparam int CNT_W = $clog2(SUM_BITS + 1);

  logic [SUM_BITS-1:0]    sum_r;
  logic [SAMPLE_BITS-1:0] add_r;
  logic                   carry_r;
  logic [CNT_W-1:0]       cnt_r;
  logic                   busy_r;
  logic                   done_r;
  logic                   bit_s;
  logic                   bit_c;

  assign bit_s = sum_r[0] ^ add_r[0] ^ carry_r;
  assign bit_c = (sum_r[0] & add_r[0]) | (carry_r & (sum_r[0] ^ add_r[0]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      cnt_r   <= '0;
      carry_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (clear) begin
        sum_r <= '0;
      end else if (start) begin
        add_r   <= sample;
        carry_r <= 1'b0;
        cnt_r   <= CNT_W'(SUM_BITS - 1);
        busy_r  <= 1'b1;
      end else if (busy_r) begin
        sum_r   <= {bit_s, sum_r[SUM_BITS-1:1]};
        add_r   <= {1'b0, add_r[SAMPLE_BITS-1:1]};
        carry_r <= bit_c;
        cnt_r   <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign sum  = sum_r;
  assign done = done_r;

endmodule

// ===== rtl/pdc_serial_div.sv =====
`timescale 1ns / 1ps
module pdc_serial_div #(
  parameter int SUM_BITS   = pdc_pkg::SAMPLE_BITS_DEF + pdc_pkg::CALIB_COUNT_BITS_DEF,
  parameter int COUNT_BITS = pdc_pkg::CALIB_COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [SUM_BITS-1:0]   dividend,
  input  logic [COUNT_BITS-1:0] divisor,
  output logic [SUM_BITS-1:0]   quotient,
  output logic                  done
);

  localparam int CNT_W = $clog2(SUM_BITS + 1);

  logic [SUM_BITS-1:0]   quo_r;
  logic [COUNT_BITS-1:0] rem_r;
  logic [COUNT_BITS-1:0] div_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  busy_r;
  logic                  done_r;
  logic [COUNT_BITS:0]   trial;
  logic [COUNT_BITS:0]   diff;
  logic                  ge;

  assign trial = {rem_r, quo_r[SUM_BITS-1]};
  assign diff  = trial - {1'b0, div_r};
  assign ge    = trial >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        quo_r  <= dividend;
        rem_r  <= '0;
        div_r  <= divisor;
        cnt_r  <= CNT_W'(SUM_BITS - 1);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
        quo_r <= {quo_r[SUM_BITS-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

// ===== rtl/pdc_band_cmp.sv =====
`timescale 1ns / 1ps
module pdc_band_cmp #(
  parameter int SAMPLE_BITS = pdc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [SAMPLE_BITS-1:0]     baseline,
  input  logic [pdc_pkg::TOL_W-2:0]  half,
  input  logic [SAMPLE_BITS-1:0]     sample,
  output pdc_pkg::band_t             flags,
  output logic                       done
);

  localparam int W     = ((SAMPLE_BITS > pdc_pkg::TOL_W) ? SAMPLE_BITS : pdc_pkg::TOL_W) + 2;
  localparam int CNT_W = $clog2(W + 1);

  logic [W-1:0]     base_r;
  logic [W-1:0]     half_r;
  logic [W-1:0]     smp_r;
  logic             cb_r;
  logic             ct_r;
  logic             c1_r;
  logic             c2_r;
  logic             nz1_r;
  logic             nz2_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  pdc_pkg::band_t   flags_r;
  logic             b_bit;
  logic             t_bit;
  logic             d1_bit;
  logic             d2_bit;
  logic             hn;
  logic             bn;
  logic             vn;

  // Bottom and top are formed one bit a cycle and fed straight into the
  // two subtractors that compare them with the sample.
  assign hn     = ~half_r[0];
  assign b_bit  = base_r[0] ^ hn ^ cb_r;
  assign t_bit  = base_r[0] ^ half_r[0] ^ ct_r;
  assign bn     = ~b_bit;
  assign vn     = ~smp_r[0];
  assign d1_bit = smp_r[0] ^ bn ^ c1_r;
  assign d2_bit = t_bit ^ vn ^ c2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        base_r <= W'(baseline);
        half_r <= W'(half);
        smp_r  <= W'(sample);
        cb_r   <= 1'b1;
        ct_r   <= 1'b0;
        c1_r   <= 1'b1;
        c2_r   <= 1'b1;
        nz1_r  <= 1'b0;
        nz2_r  <= 1'b0;
        cnt_r  <= CNT_W'(W - 1);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        base_r <= base_r >> 1;
        half_r <= half_r >> 1;
        smp_r  <= smp_r >> 1;
        cb_r   <= (base_r[0] & hn) | (cb_r & (base_r[0] ^ hn));
        ct_r   <= (base_r[0] & half_r[0]) | (ct_r & (base_r[0] ^ half_r[0]));
        c1_r   <= (smp_r[0] & bn) | (c1_r & (smp_r[0] ^ bn));
        c2_r   <= (t_bit & vn) | (c2_r & (t_bit ^ vn));
        nz1_r  <= nz1_r | d1_bit;
        nz2_r  <= nz2_r | d2_bit;
        cnt_r  <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          flags_r.lo    <= d1_bit;
          flags_r.lo_eq <= ~(nz1_r | d1_bit);
          flags_r.hi    <= d2_bit;
          flags_r.hi_eq <= ~(nz2_r | d2_bit);
          busy_r        <= 1'b0;
          done_r        <= 1'b1;
        end
      end
    end
  end

  assign flags = flags_r;
  assign done  = done_r;

endmodule

// ===== rtl/presence_detector_with_calibration.sv =====
`timescale 1ns / 1ps
// Presence detector with automatic baseline calibration and a hold timer. One sample word
// is taken at a time and yields one result word. A calibration sample is added into the
// running sum by a bit-serial adder, and the sample that ends calibration drives a
// restoring divider that yields one quotient bit per cycle (with a calibration length of
// zero the baseline is set to zero instead). A detection sample is compared with the band
// by bit-serial subtractors. The next sample is taken once the previous result is in the
// output register, so a slow consumer stalls the input by the time it holds that word.
module presence_detector_with_calibration #(
  parameter int SAMPLE_BITS      = pdc_pkg::SAMPLE_BITS_DEF,
  parameter int CALIB_COUNT_BITS = pdc_pkg::CALIB_COUNT_BITS_DEF,
  parameter int HOLD_BITS        = pdc_pkg::HOLD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pdc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pdc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [SAMPLE_BITS-1:0]          in_sample,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_interacting,
  output logic                            out_calibrating,
  output logic [1:0]                      out_machine_state
);

  localparam int SUM_BITS = SAMPLE_BITS + CALIB_COUNT_BITS;

  pdc_pkg::ctl_t state_r;
  pdc_pkg::ctl_t state_nxt;
  pdc_pkg::det_t det_r;
  pdc_pkg::det_t det_nxt;

  logic                          in_cal_r;
  logic [CALIB_COUNT_BITS-1:0]   count_r;
  logic [SAMPLE_BITS-1:0]        baseline_r;
  logic [HOLD_BITS-1:0]          hold_r;
  logic [HOLD_BITS-1:0]          hold_nxt;
  logic [pdc_pkg::TOL_W-1:0]     tol_r;
  logic [pdc_pkg::LEN_W-1:0]     len_r;
  logic [pdc_pkg::SLEEP_W-1:0]   sleep_r;

  logic                          pend_int_r;
  logic                          pend_cal_r;
  pdc_pkg::det_t                 pend_det_r;
  logic                          out_valid_r;
  logic                          out_int_r;
  logic                          out_cal_r;
  pdc_pkg::det_t                 out_det_r;

  logic                          in_fire;
  logic                          cfg_fire;
  logic                          acc_start;
  logic                          div_start;
  logic                          cmp_start;
  logic                          load_out;
  logic                          acc_clear;
  logic                          acc_done;
  logic                          div_done;
  logic                          cmp_done;
  logic [SUM_BITS-1:0]           sum;
  logic [SUM_BITS-1:0]           quotient;
  pdc_pkg::band_t                flags;
  logic [CALIB_COUNT_BITS-1:0]   len;
  logic                          more_cal;
  logic                          len_zero;
  logic [SAMPLE_BITS-1:0]        quo_sat;
  logic [HOLD_BITS-1:0]          reload;
  logic [HOLD_BITS-1:0]          hold_dec;
  logic                          reported;
  logic                          out_incl;
  logic                          in_band;

  assign in_fire   = in_valid & in_ready;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid;
  assign acc_clear = cfg_fire && (cfg_index == pdc_pkg::CFG_CAL_EN);
  assign len       = CALIB_COUNT_BITS'(len_r);
  assign more_cal  = count_r < len;
  assign len_zero  = len == '0;
  assign reload    = HOLD_BITS'(sleep_r);
  assign quo_sat   = (|quotient[SUM_BITS-1:SAMPLE_BITS]) ? '1 : quotient[SAMPLE_BITS-1:0];

  pdc_accum #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .SUM_BITS    (SUM_BITS)
  ) u_accum (
    .clk    (clk),
    .rst_n  (rst_n),
    .clear  (acc_clear),
    .start  (acc_start),
    .sample (in_sample),
    .sum    (sum),
    .done   (acc_done)
  );

  pdc_serial_div #(
    .SUM_BITS   (SUM_BITS),
    .COUNT_BITS (CALIB_COUNT_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum),
    .divisor  (len),
    .quotient (quotient),
    .done     (div_done)
  );

  pdc_band_cmp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_cmp (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmp_start),
    .baseline (baseline_r),
    .half     (tol_r[pdc_pkg::TOL_W-1:1]),
    .sample   (in_sample),
    .flags    (flags),
    .done     (cmp_done)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pdc_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (!in_cal_r) begin
            state_nxt = pdc_pkg::ST_CMP;
          end else if (more_cal) begin
            state_nxt = pdc_pkg::ST_ACCUM;
          end else if (len_zero) begin
            state_nxt = pdc_pkg::ST_WAIT;
          end else begin
            state_nxt = pdc_pkg::ST_DIV;
          end
        end
      end
      pdc_pkg::ST_ACCUM: begin
        if (acc_done) begin
          state_nxt = pdc_pkg::ST_WAIT;
        end
      end
      pdc_pkg::ST_DIV: begin
        if (div_done) begin
          state_nxt = pdc_pkg::ST_WAIT;
        end
      end
      pdc_pkg::ST_CMP: begin
        if (cmp_done) begin
          state_nxt = pdc_pkg::ST_WAIT;
        end
      end
      pdc_pkg::ST_WAIT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = pdc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pdc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready  = state_r == pdc_pkg::ST_IDLE;
    acc_start = 1'b0;
    div_start = 1'b0;
    cmp_start = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      pdc_pkg::ST_IDLE: begin
        acc_start = in_fire && in_cal_r && more_cal;
        div_start = in_fire && in_cal_r && !more_cal && !len_zero;
        cmp_start = in_fire && !in_cal_r;
      end
      pdc_pkg::ST_WAIT: begin
        load_out = !out_valid_r || out_ready;
      end
      default: begin
        load_out = 1'b0;
      end
    endcase
  end

  // One sample may fall through idle, interacting and not sure in that order.
  always_comb begin
    out_incl = flags.lo | flags.lo_eq | flags.hi | flags.hi_eq;
    in_band  = !flags.lo && !flags.hi;
    det_nxt  = det_r;
    hold_nxt = hold_r;
    reported = 1'b0;
    hold_dec = (hold_r != '0) ? hold_r - 1'b1 : '0;
    if (det_nxt == pdc_pkg::DET_IDLE && out_incl) begin
      det_nxt = pdc_pkg::DET_ACTIVE;
    end
    if (det_nxt == pdc_pkg::DET_ACTIVE) begin
      reported = 1'b1;
      if (in_band) begin
        det_nxt = pdc_pkg::DET_UNSURE;
      end
    end
    if (det_nxt == pdc_pkg::DET_UNSURE) begin
      reported = 1'b1;
      priority if (!in_band) begin
        det_nxt  = pdc_pkg::DET_ACTIVE;
        hold_nxt = reload;
      end else if (hold_dec == '0) begin
        det_nxt  = pdc_pkg::DET_IDLE;
        hold_nxt = reload;
      end else begin
        hold_nxt = hold_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pdc_pkg::ST_IDLE;
      det_r       <= pdc_pkg::DET_IDLE;
      in_cal_r    <= pdc_pkg::RST_CAL_EN;
      count_r     <= '0;
      baseline_r  <= SAMPLE_BITS'(pdc_pkg::RST_REF);
      hold_r      <= HOLD_BITS'(pdc_pkg::RST_SLEEP);
      tol_r       <= pdc_pkg::RST_TOL;
      len_r       <= pdc_pkg::RST_LEN;
      sleep_r     <= pdc_pkg::RST_SLEEP;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_fire) begin
        unique case (cfg_index)
          pdc_pkg::CFG_CAL_EN: begin
            in_cal_r <= cfg_data[0];
            count_r  <= '0;
          end
          pdc_pkg::CFG_REF: begin
            baseline_r <= SAMPLE_BITS'(cfg_data[pdc_pkg::REF_W-1:0]);
          end
          pdc_pkg::CFG_TOL: begin
            tol_r <= cfg_data[pdc_pkg::TOL_W-1:0];
          end
          pdc_pkg::CFG_LEN: begin
            len_r <= cfg_data[pdc_pkg::LEN_W-1:0];
          end
          pdc_pkg::CFG_SLEEP: begin
            sleep_r <= cfg_data[pdc_pkg::SLEEP_W-1:0];
            hold_r  <= HOLD_BITS'(cfg_data[pdc_pkg::SLEEP_W-1:0]);
          end
          default: begin
          end
        endcase
      end
      if (in_fire && in_cal_r) begin
        pend_int_r <= 1'b0;
        pend_cal_r <= more_cal;
        pend_det_r <= det_r;
        if (more_cal) begin
          count_r <= count_r + 1'b1;
        end else begin
          in_cal_r <= 1'b0;
          if (len_zero) begin
            baseline_r <= '0;
          end
        end
      end
      if (div_done) begin
        baseline_r <= quo_sat;
      end
      if (cmp_done) begin
        det_r      <= det_nxt;
        hold_r     <= hold_nxt;
        pend_int_r <= reported;
        pend_cal_r <= 1'b0;
        pend_det_r <= det_nxt;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
        out_int_r   <= pend_int_r;
        out_cal_r   <= pend_cal_r;
        out_det_r   <= pend_det_r;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_interacting   = out_int_r;
  assign out_calibrating   = out_cal_r;
  assign out_machine_state = out_det_r;

`ifndef SYNTH
  a_hold_loaded_outside_unsure: assert property (@(posedge clk) disable iff (!rst_n)
    det_r != pdc_pkg::DET_UNSURE |-> hold_r == reload)
    else $error("hold countdown not at its reload value outside not sure");

  a_cal_word_not_interacting: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_calibrating && out_interacting))
    else $error("calibration word reports interaction");

  a_one_word_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("second sample taken while one is in work");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == pdc_pkg::ST_DIV)
    else $error("divider finished outside the divide step");

  a_cmp_done_in_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_done |-> state_r == pdc_pkg::ST_CMP && !in_cal_r)
    else $error("band compare finished outside detection");
`endif

endmodule

// ===== test/presence_checker.sv =====
`timescale 1ns / 1ps
module presence_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [pdc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pdc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [15:0]                     in_sample,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic                            out_interacting,
  input  logic                            out_calibrating,
  input  logic [1:0]                      out_machine_state,
  output int                              fail_count,
  output int                              pending,
  output int                              results_seen
);
  import pdc_pkg::*;

  typedef struct packed {
    logic interacting;
    logic calibrating;
    det_t state;
  } verdict_t;

  verdict_t expected_verdicts[$];

  logic [15:0] tol_w;
  logic [15:0] cal_len;
  logic [23:0] sleep_len;
  logic        calibrating_now;
  logic [15:0] calib_count;
  logic [31:0] calib_sum;
  logic [15:0] baseline;
  det_t        det;
  logic [23:0] hold_left;

  task automatic report(input string what, input int got, input int want);
    if (fail_count < 30) begin
      $display("%0t ns: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    end
    fail_count++;
  endtask

  task automatic load_reset_state();
    tol_w           = RST_TOL;
    cal_len         = RST_LEN;
    sleep_len       = RST_SLEEP;
    calibrating_now = RST_CAL_EN;
    calib_count     = '0;
    calib_sum       = '0;
    baseline        = RST_REF;
    det             = DET_IDLE;
    hold_left       = RST_SLEEP;
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_CAL_EN: begin
        calibrating_now = data[0];
        calib_count     = '0;
        calib_sum       = '0;
      end
      CFG_REF: begin
        baseline = data[15:0];
      end
      CFG_TOL: tol_w = data[15:0];
      CFG_LEN: cal_len = data[15:0];
      CFG_SLEEP: begin
        sleep_len = data[23:0];
        hold_left = data[23:0];
      end
      default: ;
    endcase
  endtask

  task automatic advance_detector(input logic [15:0] s, output verdict_t v);
    int          half;
    int          bottom;
    int          top;
    int          level;
    logic [31:0] quot;
    logic        seen;
    seen = 1'b0;
    v.calibrating = 1'b0;
    if (calibrating_now) begin
      if (calib_count < cal_len) begin
        calib_sum     = calib_sum + 32'(s);
        calib_count   = calib_count + 16'd1;
        v.calibrating = 1'b1;
      end else begin
        quot            = (cal_len == 16'd0) ? 32'd0 : calib_sum / 32'(cal_len);
        baseline        = (quot > 32'hFFFF) ? 16'hFFFF : quot[15:0];
        calibrating_now = 1'b0;
      end
    end else begin
      half   = int'(tol_w >> 1);
      bottom = int'(baseline) - half;
      top    = int'(baseline) + half;
      level  = int'(s);
      if (det == DET_IDLE) begin
        if (level <= bottom || level >= top) det = DET_ACTIVE;
      end
      if (det == DET_ACTIVE) begin
        seen = 1'b1;
        if (level >= bottom && level <= top) det = DET_UNSURE;
      end
      if (det == DET_UNSURE) begin
        seen = 1'b1;
        if (hold_left != 24'd0) hold_left = hold_left - 24'd1;
        if (level < bottom || level > top) begin
          det       = DET_ACTIVE;
          hold_left = sleep_len;
        end else if (hold_left == 24'd0) begin
          det       = DET_IDLE;
          hold_left = sleep_len;
        end
      end
    end
    v.interacting = seen;
    v.state       = det;
  endtask

  always @(posedge clk) begin
    verdict_t v;
    verdict_t want;
    if (!rst_n) begin
      load_reset_state();
      expected_verdicts.delete();
    end else begin
      if (cfg_valid && cfg_ready) write_register(cfg_index, cfg_data);
      if (in_valid && in_ready) begin
        advance_detector(in_sample, v);
        expected_verdicts.push_back(v);
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_verdicts.size() == 0) begin
          report("result word with no prediction pending", int'(out_machine_state), -1);
        end else begin
          want = expected_verdicts.pop_front();
          if (out_interacting !== want.interacting) begin
            report("interacting", int'(out_interacting), int'(want.interacting));
          end
          if (out_calibrating !== want.calibrating) begin
            report("calibrating", int'(out_calibrating), int'(want.calibrating));
          end
          if (out_machine_state !== want.state) begin
            report("machine_state", int'(out_machine_state), int'(want.state));
          end
        end
      end
    end
    pending <= expected_verdicts.size();
  end

endmodule

// ===== test/presence_detector_with_calibration_test.sv =====
`timescale 1ns / 1ps
module presence_detector_with_calibration_test;
  import pdc_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SAMPLE_GOAL = 1700;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [15:0]           in_sample = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_interacting;
  logic                  out_calibrating;
  logic [1:0]            out_machine_state;

  int fail_count;
  int pending;
  int results_seen;

  int items_sent;
  int phases;
  int calib_runs;
  int cfg_writes;
  int burst_left;
  int ready_mode;
  int ready_left;

  always #10 clk = ~clk;

  presence_detector_with_calibration i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sample         (in_sample),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_interacting   (out_interacting),
    .out_calibrating   (out_calibrating),
    .out_machine_state (out_machine_state)
  );

  presence_checker i_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sample         (in_sample),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_interacting   (out_interacting),
    .out_calibrating   (out_calibrating),
    .out_machine_state (out_machine_state),
    .fail_count        (fail_count),
    .pending           (pending),
    .results_seen      (results_seen)
  );

  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      ready_left = $urandom_range(10, 300);
    end else begin
      ready_left = ready_left - 1;
    end
    case (ready_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= ($urandom_range(0, 5) == 0);
      default: out_ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("presence_detector_with_calibration_test failed");
    $finish;
  end

  function automatic logic [15:0] clamp(input int v);
    if (v < 0) return 16'h0000;
    if (v > 65535) return 16'hFFFF;
    return 16'(v);
  endfunction

  function automatic logic [23:0] pad16(input logic [15:0] val);
    logic [7:0] junk;
    junk = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'h00;
    return {junk, val};
  endfunction

  function automatic logic [15:0] pick_sample(input int kind, input int c, input int h);
    int v;
    case (kind)
      0: v = c - h + int'($urandom_range(0, 2 * h));
      1: begin
        case ($urandom_range(0, 3))
          0: v = c - h - 1;
          1: v = c - h;
          2: v = c + h;
          default: v = c + h + 1;
        endcase
      end
      2: begin
        if ($urandom_range(0, 1) == 1) v = c + h + 1 + int'($urandom_range(0, 3000));
        else v = c - h - 1 - int'($urandom_range(0, 3000));
      end
      3: v = int'($urandom_range(0, 65535));
      default: v = ($urandom_range(0, 1) == 1) ? 65535 : 0;
    endcase
    return clamp(v);
  endfunction

  function automatic logic [15:0] pick_tol();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'd1;
      3, 4: return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(2, 600));
    endcase
  endfunction

  function automatic logic [23:0] pick_sleep();
    case ($urandom_range(0, 15))
      0: return 24'd0;
      1: return 24'd1;
      2: return 24'hFFFFFF;
      3: return 24'($urandom_range(0, 24'hFFFFFF));
      default: return 24'($urandom_range(2, 12));
    endcase
  endfunction

  function automatic logic [15:0] pick_len();
    case ($urandom_range(0, 15))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'($urandom_range(25, 100));
      default: return 16'($urandom_range(2, 24));
    endcase
  endfunction

  task automatic send_sample(input logic [15:0] s);
    int gap;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    items_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes++;
    @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    logic [15:0] tol;
    logic [15:0] len;
    int          center;
    int          half;
    int          jitter;
    int          n;
    int          sent;
    int          kind;
    int          run;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Calibration straight out of reset, then one detection word.
    write_reg(CFG_LEN, 24'd4);
    send_sample(16'hFFFF);
    send_sample(16'hFFFF);
    send_sample(16'h0000);
    send_sample(16'hAAAA);
    send_sample(16'h5555);
    send_sample(16'h0000);
    settle();

    // Fixed baseline: inclusive and strict band edges, hold expiry.
    write_reg(CFG_CAL_EN, 24'hFFFFFE);
    write_reg(CFG_REF, 24'd1000);
    write_reg(CFG_TOL, 24'd100);
    write_reg(CFG_SLEEP, 24'd3);
    write_reg(CFG_SLEEP + 3'd1, 24'hFFFFFF);
    send_sample(16'd1000);
    send_sample(16'd950);
    send_sample(16'd1000);
    send_sample(16'd1000);
    send_sample(16'd1051);
    send_sample(16'd1050);
    send_sample(16'd949);
    settle();
    write_reg(CFG_SLEEP, 24'd0);
    send_sample(16'd2000);
    send_sample(16'd1000);
    settle();

    // Bands that reach past either end of the sample range, and a zero-width band.
    write_reg(CFG_REF, 24'd0);
    write_reg(CFG_TOL, 24'hFFFF);
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    settle();
    write_reg(CFG_REF, 24'hFFFF);
    send_sample(16'hFFFF);
    send_sample(16'h0000);
    settle();
    write_reg(CFG_TOL, 24'd0);
    send_sample(16'hFFFF);
    settle();

    // Zero length ends calibration at once; a lowered length ends it early.
    write_reg(CFG_LEN, 24'd0);
    write_reg(CFG_CAL_EN, 24'd1);
    send_sample(16'h8000);
    settle();
    write_reg(CFG_LEN, 24'hFFFF);
    write_reg(CFG_CAL_EN, 24'd1);
    repeat (6) send_sample(16'hFFFF);
    settle();
    write_reg(CFG_LEN, 24'd2);
    send_sample(16'h0000);
    send_sample(16'h7FFF);

    while (items_sent < SAMPLE_GOAL) begin
      settle();
      phases++;
      tol = pick_tol();
      half = int'(tol >> 1);
      case ($urandom_range(0, 7))
        0: center = 0;
        1: center = 65535;
        default: center = int'($urandom_range(0, 65535));
      endcase
      write_reg(CFG_TOL, pad16(tol));
      write_reg(CFG_SLEEP, pick_sleep());
      if ($urandom_range(0, 9) == 0) begin
        write_reg(CFG_SLEEP + 3'($urandom_range(1, 3)), 24'($urandom_range(0, 24'hFFFFFF)));
      end
      if ($urandom_range(0, 2) == 0) begin
        len = pick_len();
        write_reg(CFG_LEN, pad16(len));
        write_reg(CFG_CAL_EN, {23'($urandom_range(0, 23'h7FFFFF)), 1'b1});
        calib_runs++;
        jitter = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5000) : $urandom_range(0, 200);
        repeat (int'(len)) send_sample(clamp(center - jitter + int'($urandom_range(0, 2 * jitter))));
        send_sample(16'($urandom_range(0, 65535)));
      end else begin
        write_reg(CFG_CAL_EN, {23'($urandom_range(0, 23'h7FFFFF)), 1'b0});
        write_reg(CFG_REF, pad16(16'(center)));
      end
      n = $urandom_range(20, 60);
      sent = 0;
      while (sent < n) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7: kind = 0;
          8, 9, 10, 11: kind = 1;
          12, 13, 14, 15: kind = 2;
          16, 17, 18: kind = 3;
          default: kind = 4;
        endcase
        run = (kind == 0) ? $urandom_range(1, 20) : $urandom_range(1, 6);
        repeat (run) begin
          send_sample(pick_sample(kind, center, half));
          sent++;
        end
      end
    end
    settle();

    $display("Sent %0d sample words over %0d random phases, with %0d calibration runs",
             items_sent, phases, calib_runs);
    $display("and %0d register writes; %0d result words were checked.",
             cfg_writes, results_seen);
    if (fail_count == 0) begin
      $display("presence_detector_with_calibration_test passed");
    end else begin
      $display("presence_detector_with_calibration_test failed");
    end
    $finish;
  end

endmodule
